FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro checks on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that is masked while rst is high.
`define IADS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that also holds during reset.
`define IADS_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define IADS_ASSERT(label, prop)
`define IADS_ASSERT_RST(label, prop)

`endif

`endif

FILE: rtl/iads_pkg.sv
`default_nettype none

package iads_pkg;

  // Field widths of the request and result items.
  localparam int KIND_W   = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int ECOUNT_W = 8;

  // Packed stream widths.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming request
    logic check;   // check bounds and set up the scan
    logic step;    // read one word and advance the scan
    logic commit;  // final write, count update, result capture
  } iads_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;  // the request has words to move or compare
    logic last_step;  // the current step is the last of the scan
    logic out_free;   // the result register can take a new result
  } iads_stat_t;

endpackage

`default_nettype wire

FILE: rtl/indexed_array_insert_delete_search_unit.sv
// Packed table of signed 32-bit words with insert, delete and search.
// Requests enter on the slave stream: s_tuser carries the kind, s_tdata
// the position and the value. Each request gives exactly one result on
// the master stream: m_tuser carries the status, m_tdata the found value
// and the entry count after the request.
// Requests are served one at a time. The words live in a RAM with one
// write port and one registered read port, so the words are moved or
// compared one by one: an insert moves count - position words, a delete
// count - position - 1, and a search compares count words (none for
// refused requests). A new request is taken the cycle after the result
// is registered, even while that result waits for m_tready.
// If the previous result has not been taken when the next one is ready,
// the block holds in its final step until the result register frees.
// Reset empties the table and drops any pending result; the RAM needs
// no clearing since only slots below the count are ever read.
`default_nettype none
`include "assert_macros.svh"

module indexed_array_insert_delete_search_unit #(
  parameter int CAPACITY = 128
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // s_tdata, from bit 0: position[6:0], value[38:7], zero fill.
  input  wire logic [iads_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser, from bit 0: kind[1:0].
  input  wire logic [iads_pkg::KIND_W-1:0]      s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // m_tdata, from bit 0: found_value[31:0], entry_count[39:32].
  output logic      [iads_pkg::M_TDATA_W-1:0]   m_tdata,
  // m_tuser, from bit 0: status[2:0].
  output logic      [iads_pkg::STATUS_W-1:0]    m_tuser
);

  import iads_pkg::*;

  iads_cmd_t            cmd;
  iads_stat_t           stat;
  logic [VALUE_W-1:0]   found_value;
  logic [ECOUNT_W-1:0]  entry_count;

  iads_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iads_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (s_tuser),
    .in_position     (s_tdata[POS_W-1:0]),
    .in_value        (s_tdata[POS_W+VALUE_W-1:POS_W]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_status      (m_tuser),
    .out_found_value (found_value),
    .out_entry_count (entry_count)
  );

  assign m_tdata = {entry_count, found_value};

  // A result is only committed when the result register can take it.
  `IADS_ASSERT(a_commit_free, cmd.commit |-> stat.out_free)
  // Every commit shows up as a valid result on the next cycle.
  `IADS_ASSERT(a_commit_valid, cmd.commit |=> m_tvalid)
  // No scan step runs while the block is taking requests.
  `IADS_ASSERT(a_idle_no_step, s_tready |-> !cmd.step && !cmd.commit)
  // Reset leaves the block idle with no pending result.
  `IADS_ASSERT_RST(a_reset_idle, rst |=> !m_tvalid && s_tready)

endmodule

`default_nettype wire

FILE: rtl/iads_ram.sv
`default_nettype none

module iads_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/iads_ctrl.sv
`default_nettype none

module iads_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire iads_pkg::iads_stat_t stat,
  output iads_pkg::iads_cmd_t     cmd
);

  import iads_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.need_scan ? S_RUN : S_FINISH;
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (stat.last_step) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last read word is written back or compared here.
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/iads_dpath.sv
`default_nettype none

module iads_dpath #(
  parameter int CAPACITY = 128
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire iads_pkg::iads_cmd_t             cmd,
  output iads_pkg::iads_stat_t                 stat,
  input  wire logic [iads_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [iads_pkg::POS_W-1:0]      in_position,
  input  wire logic [iads_pkg::VALUE_W-1:0]    in_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [iads_pkg::STATUS_W-1:0]   out_status,
  output logic      [iads_pkg::VALUE_W-1:0]    out_found_value,
  output logic      [iads_pkg::ECOUNT_W-1:0]   out_entry_count
);

  import iads_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  // Captured request.
  logic [KIND_W-1:0]  req_kind;
  logic [POS_W-1:0]   req_pos;
  logic [VALUE_W-1:0] req_value;

  // Table state and scan control.
  logic [CNT_W-1:0]    count;
  logic [STATUS_W-1:0] chk_status;
  logic [ADDR_W-1:0]   src;
  logic [CNT_W-1:0]    remaining;
  logic                pipe_valid;
  logic [ADDR_W-1:0]   pipe_dst;
  logic                hit;

  // Check results.
  logic [CMP_W-1:0]    pos_x;
  logic [CMP_W-1:0]    cnt_x;
  logic [STATUS_W-1:0] status_chk;
  logic [CMP_W-1:0]    moves;
  logic [CMP_W-1:0]    start_src;
  logic                scan_chk;

  // Memory port signals.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [VALUE_W-1:0]  ram_rdata;
  logic                pipe_we;
  logic                final_we;

  // Result of the request being committed.
  logic [CNT_W-1:0]    count_next;
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_found;

  // Bounds checks and scan setup for the captured request.
  always_comb begin
    pos_x      = CMP_W'(req_pos);
    cnt_x      = CMP_W'(count);
    status_chk = ST_DONE;
    moves      = '0;
    start_src  = '0;
    scan_chk   = 1'b0;
    case (req_kind)
      KIND_INSERT: begin
        if (count == FULL_COUNT) begin
          status_chk = ST_FULL;
        end else if (pos_x > cnt_x) begin
          status_chk = ST_RANGE;
        end else begin
          moves     = cnt_x - pos_x;
          start_src = cnt_x - CMP_W'(1);
          scan_chk  = (moves != '0);
        end
      end
      KIND_DELETE: begin
        if (count == '0) begin
          status_chk = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_chk = ST_RANGE;
        end else begin
          moves     = cnt_x - pos_x - CMP_W'(1);
          start_src = pos_x + CMP_W'(1);
          scan_chk  = (moves != '0);
        end
      end
      KIND_SEARCH: begin
        moves    = cnt_x;
        scan_chk = (count != '0);
      end
      default: begin
        status_chk = ST_DONE;
      end
    endcase
  end

  assign stat.need_scan = scan_chk;
  assign stat.last_step = (remaining == CNT_W'(1));
  assign stat.out_free  = !out_valid || out_ready;

  // Shifted words are written in the cycle after their read; the new word
  // of an insert goes in at commit.
  assign pipe_we   = pipe_valid && (req_kind == KIND_INSERT || req_kind == KIND_DELETE);
  assign final_we  = cmd.commit && (req_kind == KIND_INSERT) && (chk_status == ST_DONE);
  assign ram_we    = pipe_we || final_we;
  assign ram_waddr = pipe_we ? pipe_dst : pos_x[ADDR_W-1:0];
  assign ram_wdata = pipe_we ? ram_rdata : req_value;

  iads_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (src),
    .rdata (ram_rdata)
  );

  // Outcome of the request at commit.
  always_comb begin
    count_next = count;
    res_status = chk_status;
    res_found  = '0;
    if (chk_status == ST_DONE) begin
      case (req_kind)
        KIND_INSERT: begin
          count_next = count + CNT_W'(1);
        end
        KIND_DELETE: begin
          count_next = count - CNT_W'(1);
        end
        KIND_SEARCH: begin
          res_status = hit ? ST_DONE : ST_MISS;
          res_found  = hit ? req_value : '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // Request capture and scan registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind  <= in_kind;
      req_pos   <= in_position;
      req_value <= in_value;
    end
    if (cmd.check) begin
      chk_status <= status_chk;
      src        <= start_src[ADDR_W-1:0];
      remaining  <= moves[CNT_W-1:0];
    end else if (cmd.step) begin
      src       <= (req_kind == KIND_INSERT) ? src - ADDR_W'(1) : src + ADDR_W'(1);
      remaining <= remaining - CNT_W'(1);
    end
    if (cmd.step) begin
      pipe_dst <= (req_kind == KIND_INSERT) ? src + ADDR_W'(1) : src - ADDR_W'(1);
    end
  end

  // Control state: count, read pipeline, match flag, result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pipe_valid <= 1'b0;
      hit        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pipe_valid <= cmd.step;
      if (cmd.check) begin
        hit <= 1'b0;
      end else if (pipe_valid && req_kind == KIND_SEARCH && ram_rdata == req_value) begin
        hit <= 1'b1;
      end
      if (cmd.commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status      <= res_status;
      out_found_value <= res_found;
      out_entry_count <= ECOUNT_W'(count_next);
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/indexed_array_insert_delete_search_unit_tb.sv
`timescale 1ns / 1ps

module indexed_array_insert_delete_search_unit_tb;
  import iads_pkg::*;

  localparam int TABLE_DEPTH = 128;
  // The kind code that the block ignores.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // One result as the block reports it.
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] found_value;
    logic [ECOUNT_W-1:0]       entry_count;
  } table_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  // s_tdata, from bit 0: position[6:0], value[38:7], zero fill.
  logic [S_TDATA_W-1:0] s_tdata;
  // s_tuser, from bit 0: kind[1:0].
  logic [KIND_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  // m_tdata, from bit 0: found_value[31:0], entry_count[39:32].
  logic [M_TDATA_W-1:0] m_tdata;
  // m_tuser, from bit 0: status[2:0].
  logic [STATUS_W-1:0] m_tuser;

  // Shadow copy of the table and its fill level.
  logic signed [VALUE_W-1:0] table_words [TABLE_DEPTH];
  int table_fill = 0;

  table_result_t pending_results[$];
  int mismatch_count = 0;
  bit idle_off = 1'b0;
  int rx_hold_cycles = 0;

  indexed_array_insert_delete_search_unit #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow table and returns the result it should give.
  function automatic table_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic signed [VALUE_W-1:0] val);
    table_result_t r;
    int i;
    r.status = ST_DONE;
    r.found_value = '0;
    case (kind)
      KIND_INSERT: begin
        if (table_fill >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (int'(pos) > table_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (i = table_fill; i > int'(pos); i--) table_words[i] = table_words[i-1];
          table_words[pos] = val;
          table_fill++;
        end
      end
      KIND_DELETE: begin
        if (table_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pos) >= table_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < table_fill; i++) table_words[i] = table_words[i+1];
          table_fill--;
        end
      end
      KIND_SEARCH: begin
        r.status = ST_MISS;
        for (i = 0; i < table_fill; i++) begin
          if (table_words[i] == val) begin
            r.status = ST_DONE;
            r.found_value = val;
            break;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = table_fill[ECOUNT_W-1:0];
    return r;
  endfunction

  // Word to store or look up: half the time random, else an extreme or a repeat-prone small value.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  // Offers one request, waits for its transaction, and records the expected result.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] val);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {{(S_TDATA_W - VALUE_W - POS_W){1'b0}}, val, pos};
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_results.push_back(apply_request(kind, pos, val));
  endtask

  // Boundary values, every kind and every refusal but a full table, on a small table.
  task automatic test_directed_cases();
    send_request(KIND_DELETE, 7'd0, 32'd0);
    send_request(KIND_SEARCH, 7'd0, 32'd0);
    send_request(KIND_INSERT, 7'd1, 32'd9);
    send_request(KIND_INSERT, 7'd0, 32'h8000_0000);
    send_request(KIND_INSERT, 7'd1, 32'h7FFF_FFFF);
    send_request(KIND_INSERT, 7'd0, 32'h0000_0000);
    send_request(KIND_INSERT, 7'd1, 32'h5555_5555);
    send_request(KIND_INSERT, 7'd4, 32'hAAAA_AAAA);
    send_request(KIND_INSERT, 7'h7F, 32'd1);
    send_request(KIND_SEARCH, 7'h55, 32'h8000_0000);
    send_request(KIND_SEARCH, 7'h2A, 32'h7FFF_FFFF);
    send_request(KIND_SEARCH, 7'd0, 32'hAAAA_AAAA);
    send_request(KIND_SEARCH, 7'd0, 32'd12345);
    send_request(KIND_DELETE, 7'd5, 32'd0);
    send_request(KIND_DELETE, 7'h7F, 32'd0);
    send_request(KIND_DELETE, 7'd4, 32'd0);
    send_request(KIND_DELETE, 7'd0, 32'd0);
    send_request(KIND_SEARCH, 7'd0, 32'd0);
    send_request(KIND_UNUSED, 7'h7F, 32'hFFFF_FFFF);
    send_request(KIND_UNUSED, 7'd0, 32'd0);
    send_request(KIND_DELETE, 7'd1, 32'd0);
    send_request(KIND_INSERT, 7'd0, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 7'd2, 32'hFFFF_FFFF);
    send_request(KIND_SEARCH, 7'd0, 32'hFFFF_FFFF);
  endtask

  // Grows the table to capacity, then pokes at the full table.
  task automatic test_fill_to_capacity();
    while (table_fill < TABLE_DEPTH) begin
      send_request(KIND_INSERT, POS_W'($urandom_range(0, table_fill)), pick_value());
    end
    send_request(KIND_INSERT, 7'd0, pick_value());
    send_request(KIND_INSERT, 7'h7F, pick_value());
    send_request(KIND_SEARCH, 7'd0, table_words[TABLE_DEPTH-1]);
    send_request(KIND_SEARCH, 7'd0, table_words[0]);
    send_request(KIND_DELETE, 7'h7F, 32'd0);
    send_request(KIND_INSERT, 7'h7F, pick_value());
  endtask

  // Empties the table from random slots, searching now and then.
  task automatic test_drain_to_empty();
    logic [VALUE_W-1:0] gone;
    int slot;
    while (table_fill > 0) begin
      slot = $urandom_range(0, table_fill - 1);
      gone = table_words[slot];
      send_request(KIND_DELETE, POS_W'(slot), 32'd0);
      if ($urandom_range(0, 3) == 0) begin
        send_request(KIND_SEARCH, 7'd0, gone);
      end
    end
    send_request(KIND_DELETE, 7'd0, 32'd0);
    send_request(KIND_DELETE, 7'h7F, 32'd0);
    send_request(KIND_SEARCH, 7'd0, 32'd0);
  endtask

  // The receiver stops for a long time while requests keep coming.
  task automatic test_output_backpressure();
    int i;
    rx_hold_cycles = 400;
    idle_off = 1'b1;
    for (i = 0; i < 40; i++) begin
      send_request(i % 3 == 2 ? KIND_SEARCH : KIND_INSERT,
                   POS_W'($urandom_range(0, table_fill < TABLE_DEPTH ? table_fill
                                                                    : TABLE_DEPTH - 1)),
                   pick_value());
    end
    idle_off = 1'b0;
  endtask

  // Mixed traffic whose bias swings between growing and shrinking the table.
  task automatic test_random_traffic(input int n_items);
    int i;
    int roll;
    bit grow;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0] pos;
    logic [VALUE_W-1:0] val;
    for (i = 0; i < n_items; i++) begin
      idle_off = (i % 250) >= 200;
      grow = ((i / 300) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        kind = KIND_UNUSED;
      end else if (roll < 30) begin
        kind = KIND_SEARCH;
      end else if (roll < (grow ? 90 : 40)) begin
        kind = KIND_INSERT;
      end else begin
        kind = KIND_DELETE;
      end
      val = pick_value();
      if (kind == KIND_SEARCH && table_fill > 0 && $urandom_range(0, 99) < 60) begin
        val = table_words[$urandom_range(0, table_fill - 1)];
      end
      // Mostly legal positions, with some arbitrary ones mixed in.
      if ($urandom_range(0, 99) < 12) begin
        pos = POS_W'($urandom_range(0, 127));
      end else if (kind == KIND_INSERT) begin
        pos = POS_W'($urandom_range(0, table_fill < TABLE_DEPTH ? table_fill : TABLE_DEPTH - 1));
      end else begin
        pos = table_fill > 0 ? POS_W'($urandom_range(0, table_fill - 1)) : '0;
      end
      send_request(kind, pos, val);
    end
    idle_off = 1'b0;
  endtask

  // Result side: random or long stalls, then check each transaction against the oldest expectation.
  initial begin
    int stall;
    table_result_t want;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = idle_off ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d found_value %0d entry_count %0d",
               m_tuser, $signed(m_tdata[31:0]), m_tdata[39:32]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tuser);
          mismatch_count++;
        end
        if (m_tdata[31:0] !== want.found_value) begin
          $error("found_value: expected %0d, actual %0d", want.found_value,
                 $signed(m_tdata[31:0]));
          mismatch_count++;
        end
        if (m_tdata[39:32] !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, m_tdata[39:32]);
          mismatch_count++;
        end
      end
      @(negedge clk);
    end
  end

  // Test sequence.
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_fill_to_capacity();
    test_drain_to_empty();
    test_output_backpressure();
    test_random_traffic(1300);
    @(negedge clk);
    s_tvalid <= 1'b0;
    // Let outstanding results arrive, then watch for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
